@@ rtl/core/pth_pkg.sv @@
package pth_pkg;

    localparam int ANG_W   = 18;
    localparam int ERR_W   = 20;
    localparam int ACC_W   = 40;
    localparam int ACC_HW  = ACC_W / 2;
    localparam int DB_W    = 17;
    localparam int GAIN_W  = 16;
    localparam int DRV_W   = 16;
    localparam int MA_W    = ERR_W + 1;
    localparam int MB_W    = GAIN_W + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int SUM_W   = 59;
    localparam int P_SHIFT = 16;
    localparam int I_SHIFT = ACC_HW;
    localparam int RND_SH  = 20;
    localparam int DFULL_W = SUM_W - RND_SH;
    localparam int IDX_W   = 2;

    localparam logic [DB_W-1:0]   DEADBAND_RST   = DB_W'(64);
    localparam logic [GAIN_W-1:0] CYCLE_TIME_RST = GAIN_W'(1311);

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_STEP  = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_DEADBAND   = 2'd0,
        REG_P_GAIN     = 2'd1,
        REG_I_GAIN     = 2'd2,
        REG_CYCLE_TIME = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DB_W-1:0]   deadband;
        logic [GAIN_W-1:0] p_gain;
        logic [GAIN_W-1:0] i_gain;
        logic [GAIN_W-1:0] cycle_time;
    } t_cfg;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive;
        logic                    turning;
        logic                    reached;
    } t_res;

endpackage

@@ rtl/core/pi_turn_to_heading_top.sv @@
// PI heading controller with deadband.
// Input channel: i_in_valid / o_in_stall with i_mode, i_gyro_angle and
// i_target_angle; a transfer happens on a clock edge with valid high and
// stall low. Mode 0 starts a turn, mode 1 runs one control step, mode 2 stops.
// Output channel: o_out_valid / i_out_stall with o_drive, o_turning and
// o_reached; every input item gives exactly one result.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// ready is always high. Index 0 deadband, 1 p_gain, 2 i_gain, 3 cycle_time.
// Start, stop and deadband-reached items, and steps with no turn active, go
// from the evaluate state straight to the output hold state; a full control
// step uses the single shared 21x17 multiplier four times, then the wide sum.
// One item is in work at a time; o_in_stall is high until its result has
// moved into the output register, so the next transfer is taken the cycle
// after that.
// A stalled result holds in the output register; the block then waits with
// its next result and stalls its input.
// Reset clears the turn state and integral and loads the register defaults.
module pi_turn_to_heading_top
    import pth_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_mode,
    input  logic signed [ANG_W-1:0] i_gyro_angle,
    input  logic signed [ANG_W-1:0] i_target_angle,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [DRV_W-1:0] o_drive,
    output logic                    o_turning,
    output logic                    o_reached,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    t_cfg                     cfg;
    t_res                     res;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;

    assign o_cfg_ready = 1'b1;

    pth_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pth_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pth_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_gyro_angle   (i_gyro_angle),
        .i_target_angle (i_target_angle),
        .o_mul_a        (mul_a),
        .o_mul_b        (mul_b),
        .i_prod         (prod),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_res          (res)
    );

    assign o_drive   = res.drive;
    assign o_turning = res.turning;
    assign o_reached = res.reached;

endmodule

@@ rtl/core/pth_cfg.sv @@
module pth_cfg
    import pth_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEADBAND:   n_cfg.deadband   = i_cfg_data[DB_W-1:0];
                REG_P_GAIN:     n_cfg.p_gain     = i_cfg_data[GAIN_W-1:0];
                REG_I_GAIN:     n_cfg.i_gain     = i_cfg_data[GAIN_W-1:0];
                REG_CYCLE_TIME: n_cfg.cycle_time = i_cfg_data[GAIN_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband   <= DEADBAND_RST;
            r_cfg.p_gain     <= '0;
            r_cfg.i_gain     <= '0;
            r_cfg.cycle_time <= CYCLE_TIME_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/pth_mul.sv @@
module pth_mul
    import pth_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MA_W-1:0]   i_a,
    input  logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/pth_core.sv @@
module pth_core
    import pth_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_mode,
    input  logic signed [ANG_W-1:0]  i_gyro_angle,
    input  logic signed [ANG_W-1:0]  i_target_angle,
    output logic signed [MA_W-1:0]   o_mul_a,
    output logic signed [MB_W-1:0]   o_mul_b,
    input  logic signed [PROD_W-1:0] i_prod,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_res                     o_res
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EVAL = 9'b000000010,
        S_MCT  = 9'b000000100,
        S_ACC  = 9'b000001000,
        S_MIL  = 9'b000010000,
        S_MIH  = 9'b000100000,
        S_SUM  = 9'b001000000,
        S_RND  = 9'b010000000,
        S_HOLD = 9'b100000000
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_active, n_active;
    logic signed [ANG_W-1:0]  r_goal, n_goal;
    logic signed [ANG_W-1:0]  r_ref, n_ref;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    t_mode                    r_mode;
    logic signed [ANG_W-1:0]  r_angle;
    logic signed [ANG_W-1:0]  r_target;
    t_res                     r_res, n_res;
    t_res                     r_out;
    logic                     r_out_valid;

    logic                     accept;
    logic                     out_load;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         mag;
    logic                     in_band;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic signed [SUM_W-1:0]  prod_ext;
    logic signed [SUM_W-1:0]  rnd;
    logic signed [DFULL_W-1:0] drv_full;
    logic signed [DRV_W-1:0]  drv_sat;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);

    assign err = ERR_W'(r_goal) - ERR_W'(r_angle) + ERR_W'(r_ref);
    assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign in_band = (mag <= ERR_W'(i_cfg.deadband));

    assign acc_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(i_prod);
    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    assign prod_ext = SUM_W'(i_prod);
    assign rnd      = r_sum + (SUM_W'(1) <<< (RND_SH - 1));
    assign drv_full = rnd[SUM_W-1:RND_SH];

    always_comb begin
        if (!drv_full[DFULL_W-1] && (|drv_full[DFULL_W-2:DRV_W-1])) begin
            drv_sat = {1'b0, {(DRV_W-1){1'b1}}};
        end else if (drv_full[DFULL_W-1] && !(&drv_full[DFULL_W-2:DRV_W-1])) begin
            drv_sat = {1'b1, {(DRV_W-1){1'b0}}};
        end else begin
            drv_sat = drv_full[DRV_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        o_mul_a = MA_W'(r_err);
        o_mul_b = MB_W'(i_cfg.cycle_time);
        case (r_state)
            S_ACC: begin
                o_mul_b = MB_W'(i_cfg.p_gain);
            end
            S_MIL: begin
                o_mul_a = $signed({1'b0, r_acc[ACC_HW-1:0]});
                o_mul_b = MB_W'(i_cfg.i_gain);
            end
            S_MIH: begin
                o_mul_a = MA_W'($signed(r_acc[ACC_W-1:ACC_HW]));
                o_mul_b = MB_W'(i_cfg.i_gain);
            end
            default: begin
                o_mul_a = MA_W'(r_err);
                o_mul_b = MB_W'(i_cfg.cycle_time);
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_goal   = r_goal;
        n_ref    = r_ref;
        n_acc    = r_acc;
        n_err    = r_err;
        n_sum    = r_sum;
        n_res    = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_res.drive   = '0;
                n_res.reached = 1'b0;
                n_state       = S_HOLD;
                case (r_mode)
                    MODE_START: begin
                        n_ref    = r_angle;
                        n_goal   = r_target;
                        n_active = 1'b1;
                    end
                    MODE_STOP: begin
                        n_active = 1'b0;
                        n_goal   = '0;
                        n_acc    = '0;
                    end
                    MODE_STEP: begin
                        if (r_active) begin
                            if (in_band) begin
                                n_active      = 1'b0;
                                n_goal        = '0;
                                n_acc         = '0;
                                n_res.reached = 1'b1;
                            end else begin
                                n_err   = err;
                                n_state = S_MCT;
                            end
                        end
                    end
                    default: begin
                        n_active = r_active;
                    end
                endcase
                n_res.turning = n_active;
            end
            S_MCT: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc   = acc_sat;
                n_state = S_MIL;
            end
            S_MIL: begin
                n_sum   = prod_ext <<< P_SHIFT;
                n_state = S_MIH;
            end
            S_MIH: begin
                n_sum   = r_sum + prod_ext;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum   = r_sum + (prod_ext <<< I_SHIFT);
                n_state = S_RND;
            end
            S_RND: begin
                n_res.drive = drv_sat;
                n_state     = S_HOLD;
            end
            S_HOLD: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_goal      <= '0;
            r_ref       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_goal   <= n_goal;
            r_ref    <= n_ref;
            r_acc    <= n_acc;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= n_err;
        r_sum <= n_sum;
        r_res <= n_res;
        if (accept) begin
            r_mode   <= t_mode'(i_mode);
            r_angle  <= i_gyro_angle;
            r_target <= i_target_angle;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
